// ===== hdl/sclt_pkg.sv =====
// Shared constants and controller/datapath types for the statement cache LFU table.
`default_nettype none
package sclt_pkg;

   // Table geometry and field widths
   localparam int CAPACITY    = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int KEY_WIDTH   = 64;
   localparam int ID_WIDTH    = 32;
   localparam int LIMIT_WIDTH = 7;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(64);

   // Slot address and occupancy widths follow from the capacity
   localparam int SLOT_AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W   = $clog2(CAPACITY + 1);

   // One stored statement
   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key_high;
      logic [KEY_WIDTH-1:0]   key_low;
      logic [ID_WIDTH-1:0]    id;
      logic [COUNT_WIDTH-1:0] binds;
   } sclt_entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic               load;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
      logic               commit;
   } sclt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_free;
   } sclt_status_type;

endpackage
`default_nettype wire

// ===== hdl/sclt_if.sv =====
// Valid/ready channel interfaces: request, response and register write.
`default_nettype none

interface sclt_req_if import sclt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [KEY_WIDTH-1:0] query_hash_high;
   logic [KEY_WIDTH-1:0] query_hash_low;
   modport source (output valid, op, query_hash_high, query_hash_low, input ready);
   modport sink   (input valid, op, query_hash_high, query_hash_low, output ready);
endinterface

interface sclt_rsp_if import sclt_pkg::*;;
   logic                valid;
   logic                ready;
   logic                hit;
   logic [ID_WIDTH-1:0] statement_id;
   logic                evicted;
   logic [ID_WIDTH-1:0] evicted_id;
   modport source (output valid, hit, statement_id, evicted, evicted_id, input ready);
   modport sink   (input valid, hit, statement_id, evicted, evicted_id, output ready);
endinterface

interface sclt_csr_if import sclt_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [LIMIT_WIDTH-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sclt_datapath.sv =====
// Datapath: slot memory, scan trackers, occupancy/id counters and result register.
`default_nettype none
module sclt_datapath import sclt_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sclt_cmd_type           cmd,
   output sclt_status_type             status,
   input  wire logic                   req_op,
   input  wire logic [KEY_WIDTH-1:0]   req_hash_high,
   input  wire logic [KEY_WIDTH-1:0]   req_hash_low,
   input  wire logic                   csr_write,
   input  wire logic [LIMIT_WIDTH-1:0] csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_hit,
   output logic [ID_WIDTH-1:0]         rsp_statement_id,
   output logic                        rsp_evicted,
   output logic [ID_WIDTH-1:0]         rsp_evicted_id
);

   localparam int CMP_W = (OCC_W > LIMIT_WIDTH) ? OCC_W : LIMIT_WIDTH;

   // Slot storage and per-slot valid bits
   sclt_entry_type       slot_mem [CAPACITY];
   sclt_entry_type       rd_data_ff;
   logic [CAPACITY-1:0]  valid_ff;

   // Configuration and counters
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [OCC_W-1:0]       occ_ff;
   logic [ID_WIDTH-1:0]    next_id_ff;

   // Captured request
   logic                 op_ff;
   logic [KEY_WIDTH-1:0] key_hi_ff;
   logic [KEY_WIDTH-1:0] key_lo_ff;

   // Scan pipeline and trackers
   logic                   eval_ff;
   logic [SLOT_AW-1:0]     eval_addr_ff;
   logic                   hit_ff;
   logic [SLOT_AW-1:0]     hit_slot_ff;
   logic [ID_WIDTH-1:0]    hit_id_ff;
   logic [COUNT_WIDTH-1:0] hit_binds_ff;
   logic                   have_ff;
   logic [SLOT_AW-1:0]     victim_slot_ff;
   logic [ID_WIDTH-1:0]    victim_id_ff;
   logic [COUNT_WIDTH-1:0] victim_binds_ff;
   logic                   free_found_ff;
   logic [SLOT_AW-1:0]     free_slot_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [ID_WIDTH-1:0] rsp_id_ff;
   logic                rsp_evicted_ff;
   logic [ID_WIDTH-1:0] rsp_evicted_id_ff;

   logic                   slot_live;
   logic                   key_match;
   logic                   take_victim;
   logic                   take_free;
   logic                   evict_now;
   logic [SLOT_AW-1:0]     ins_slot;
   logic [COUNT_WIDTH-1:0] binds_inc;
   logic                   mem_we;
   logic [SLOT_AW-1:0]     mem_waddr;
   sclt_entry_type         mem_wdata;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem[cmd.rd_addr];
      end
   end

   // Per-beat compare of the slot read last cycle
   always_comb begin
      slot_live   = eval_ff && valid_ff[eval_addr_ff];
      key_match   = slot_live && (rd_data_ff.key_high == key_hi_ff)
                    && (rd_data_ff.key_low == key_lo_ff);
      take_victim = slot_live && (!have_ff ||
                    ({rd_data_ff.binds, rd_data_ff.id} < {victim_binds_ff, victim_id_ff}));
      take_free   = eval_ff && !valid_ff[eval_addr_ff] && !free_found_ff;
   end

   // Commit decisions
   always_comb begin
      evict_now = !hit_ff && have_ff && (occ_ff != '0) &&
                  ((CMP_W'(occ_ff) >= CMP_W'(limit_ff)) || (occ_ff >= OCC_W'(CAPACITY)));
      ins_slot  = evict_now ? victim_slot_ff : free_slot_ff;
      binds_inc = (hit_binds_ff == '1) ? hit_binds_ff : hit_binds_ff + COUNT_WIDTH'(1);
      mem_we    = cmd.commit && (!hit_ff || op_ff);
      mem_waddr = hit_ff ? hit_slot_ff : ins_slot;
      mem_wdata.key_high = key_hi_ff;
      mem_wdata.key_low  = key_lo_ff;
      mem_wdata.id       = hit_ff ? hit_id_ff : next_id_ff;
      mem_wdata.binds    = hit_ff ? binds_inc : COUNT_WIDTH'(op_ff);
   end

   // Scan address pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= 1'b0;
      end else begin
         eval_ff <= cmd.rd_en;
      end
      eval_addr_ff <= cmd.rd_addr;
   end

   // Request capture and trackers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_op;
         key_hi_ff     <= req_hash_high;
         key_lo_ff     <= req_hash_low;
         hit_ff        <= 1'b0;
         have_ff       <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (key_match && !hit_ff) begin
            hit_ff       <= 1'b1;
            hit_slot_ff  <= eval_addr_ff;
            hit_id_ff    <= rd_data_ff.id;
            hit_binds_ff <= rd_data_ff.binds;
         end
         if (take_victim) begin
            have_ff         <= 1'b1;
            victim_slot_ff  <= eval_addr_ff;
            victim_id_ff    <= rd_data_ff.id;
            victim_binds_ff <= rd_data_ff.binds;
         end
         if (take_free) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= eval_addr_ff;
         end
      end
   end

   // Table state: limit, valid bits, occupancy, id counter
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         valid_ff   <= '0;
         occ_ff     <= '0;
         next_id_ff <= '0;
      end else begin
         if (csr_write) begin
            limit_ff <= csr_data;
         end
         if (cmd.commit && !hit_ff) begin
            valid_ff[ins_slot] <= 1'b1;
            next_id_ff         <= next_id_ff + ID_WIDTH'(1);
            if (!evict_now) begin
               occ_ff <= occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_hit_ff        <= hit_ff;
         rsp_id_ff         <= hit_ff ? hit_id_ff : next_id_ff;
         rsp_evicted_ff    <= evict_now;
         rsp_evicted_id_ff <= evict_now ? victim_id_ff : '0;
      end
   end

   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_statement_id = rsp_id_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_id   = rsp_evicted_id_ff;

   // Occupancy tracks the valid bits
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == occ_ff)
      else $error("occupancy does not match valid bit count");

   // A new result never overwrites one still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // A hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("hit with eviction");

   // A miss that does not evict has a free slot to fill
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !hit_ff && !evict_now) |-> free_found_ff)
      else $error("insert without free slot");

endmodule
`default_nettype wire

// ===== hdl/sclt_controller.sv =====
// Controller: sequences request capture, slot scan, last compare and commit.
`default_nettype none
module sclt_controller import sclt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output sclt_cmd_type         cmd,
   input  wire sclt_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } sclt_state_type;

   sclt_state_type     state_ff;
   sclt_state_type     state_in;
   logic [SLOT_AW-1:0] cnt_ff;
   logic [SLOT_AW-1:0] cnt_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.rd_addr = cnt_ff;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == SLOT_AW'(CAPACITY - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + SLOT_AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/statement_cache_lfu_table_core.sv =====
// Top level of the statement cache LFU table: controller, datapath and channel wiring.
//
// Caches up to 64 prepared statements keyed by a 128-bit query hash. Each request
// beat is answered by exactly one response beat: a hit returns the stored id, a miss
// assigns the next sequential id and, when the cache is not empty and occupancy has
// reached the cache limit or the capacity, evicts the entry with the fewest binds
// (smallest id on a tie) and reports its id. Binds count up and saturate. A request
// passes through acceptance, a scan reading the slots one per cycle through the
// single read port of the slot memory, a final compare and a commit, which loads
// its response. The commit waits while an earlier response is still unaccepted. The
// response sits in an output register, so a new request is accepted in the cycle after
// the previous one commits, even if its response is not yet taken.
// The cache limit register may be written at any time the block is idle; it resets to 64.
`default_nettype none
module statement_cache_lfu_table_core import sclt_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   sclt_req_if.sink    req_bus,
   sclt_rsp_if.source  rsp_bus,
   sclt_csr_if.sink    csr_bus
);

   sclt_cmd_type    cmd;
   sclt_status_type status;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   sclt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sclt_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_bus.op),
      .req_hash_high    (req_bus.query_hash_high),
      .req_hash_low     (req_bus.query_hash_low),
      .csr_write        (csr_bus.valid),
      .csr_data         (csr_bus.data),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_hit          (rsp_bus.hit),
      .rsp_statement_id (rsp_bus.statement_id),
      .rsp_evicted      (rsp_bus.evicted),
      .rsp_evicted_id   (rsp_bus.evicted_id)
   );

endmodule
`default_nettype wire

// ===== sim/statement_cache_lfu_table_core_tb.sv =====
// Self-checking testbench for the statement cache LFU table core.
module statement_cache_lfu_table_core_tb;
   import sclt_pkg::*;

   // Key and beat types seen by the testbench
   typedef struct packed {
      logic [KEY_WIDTH-1:0] hi;
      logic [KEY_WIDTH-1:0] lo;
   } stmt_key_type;

   typedef struct packed {
      logic                 op;
      logic [KEY_WIDTH-1:0] hi;
      logic [KEY_WIDTH-1:0] lo;
   } stmt_req_type;

   typedef struct packed {
      logic                hit;
      logic [ID_WIDTH-1:0] statement_id;
      logic                evicted;
      logic [ID_WIDTH-1:0] evicted_id;
   } stmt_answer_type;

   localparam logic OP_PARSE = 1'b0;
   localparam logic OP_BIND  = 1'b1;

   localparam int IDLE_PCT       = 17;
   localparam int RSP_STALL_LEN  = 500;
   localparam int QUIET_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int RANDOM_PHASES  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sclt_req_if req_if ();
   sclt_rsp_if rsp_if ();
   sclt_csr_if csr_if ();

   statement_cache_lfu_table_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the table
   logic                   shadow_used  [CAPACITY];
   logic [KEY_WIDTH-1:0]   shadow_kh    [CAPACITY];
   logic [KEY_WIDTH-1:0]   shadow_kl    [CAPACITY];
   logic [ID_WIDTH-1:0]    shadow_sid   [CAPACITY];
   logic [COUNT_WIDTH-1:0] shadow_binds [CAPACITY];
   logic [ID_WIDTH-1:0]    shadow_next_sid = '0;
   int                     shadow_occ      = 0;
   logic [LIMIT_WIDTH-1:0] shadow_limit    = LIMIT_RESET;

   stmt_req_type    stmts_to_send [$];
   stmt_answer_type answers_due   [$];

   bit sender_hold = 1'b0;
   bit no_idle     = 1'b0;
   int rsp_stalls_requested = 0;
   int rsp_stalls_started   = 0;
   int rsp_stall_left       = 0;

   int mismatch_count = 0;
   int stmts_sent     = 0;
   int hits_seen      = 0;
   int evicts_seen    = 0;
   int limit_writes   = 0;
   int quiet_cycles   = 0;

   // Lookup / insert / evict, same order of effects as the block
   function automatic stmt_answer_type lookup_statement(input logic is_bind,
                                                         input logic [KEY_WIDTH-1:0] kh,
                                                         input logic [KEY_WIDTH-1:0] kl);
      stmt_answer_type ans;
      int s;
      int found;
      int victim;
      int eff_limit;
      ans = '0;
      found = -1;
      victim = -1;
      for (s = 0; s < CAPACITY; s++) begin
         if (found < 0 && shadow_used[s] && shadow_kh[s] == kh && shadow_kl[s] == kl)
            found = s;
      end
      if (found >= 0) begin
         if (is_bind && shadow_binds[found] != {COUNT_WIDTH{1'b1}})
            shadow_binds[found] = shadow_binds[found] + 1'b1;
         ans.hit = 1'b1;
         ans.statement_id = shadow_sid[found];
         return ans;
      end
      // miss: evict fewest binds, smallest id on a tie
      eff_limit = (int'(shadow_limit) > CAPACITY) ? CAPACITY : int'(shadow_limit);
      if (shadow_occ > 0 && (shadow_occ >= eff_limit || shadow_occ >= CAPACITY)) begin
         for (s = 0; s < CAPACITY; s++) begin
            if (shadow_used[s]) begin
               if (victim < 0 || shadow_binds[s] < shadow_binds[victim] ||
                   (shadow_binds[s] == shadow_binds[victim] &&
                    shadow_sid[s] < shadow_sid[victim]))
                  victim = s;
            end
         end
         if (victim >= 0) begin
            ans.evicted = 1'b1;
            ans.evicted_id = shadow_sid[victim];
            shadow_used[victim] = 1'b0;
            shadow_occ--;
         end
      end
      ans.statement_id = shadow_next_sid;
      shadow_next_sid = shadow_next_sid + 1'b1;
      // lowest free slot takes the new entry
      for (s = 0; s < CAPACITY; s++) begin
         if (found < 0 && !shadow_used[s]) begin
            found = s;
            shadow_used[s] = 1'b1;
            shadow_kh[s] = kh;
            shadow_kl[s] = kl;
            shadow_sid[s] = ans.statement_id;
            shadow_binds[s] = is_bind ? COUNT_WIDTH'(1) : '0;
            shadow_occ++;
         end
      end
      return ans;
   endfunction

   // Request driver: takes beats from the send queue, predicts at acceptance
   always @(posedge clock) begin : req_driver
      logic            fire;
      stmt_req_type    item;
      stmt_answer_type ans;
      if (reset) begin
         req_if.valid           <= 1'b0;
         req_if.op              <= OP_PARSE;
         req_if.query_hash_high <= '0;
         req_if.query_hash_low  <= '0;
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) begin
            ans = lookup_statement(req_if.op, req_if.query_hash_high, req_if.query_hash_low);
            answers_due.push_back(ans);
            stmts_sent++;
            if (ans.hit) hits_seen++;
            if (ans.evicted) evicts_seen++;
         end
         if (!req_if.valid || fire) begin
            if (stmts_to_send.size() != 0 && !sender_hold &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               item = stmts_to_send.pop_front();
               req_if.valid           <= 1'b1;
               req_if.op              <= item.op;
               req_if.query_hash_high <= item.hi;
               req_if.query_hash_low  <= item.lo;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each beat against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      stmt_answer_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response beat: hit=%0d id=%0d ev=%0d ev_id=%0d",
                           rsp_if.hit, rsp_if.statement_id, rsp_if.evicted,
                           rsp_if.evicted_id);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_if.hit !== want.hit || rsp_if.statement_id !== want.statement_id ||
                   rsp_if.evicted !== want.evicted ||
                   rsp_if.evicted_id !== want.evicted_id) begin
                  if (mismatch_count < 10) begin
                     $display("mismatch: exp hit=%0d id=%0d ev=%0d ev_id=%0d",
                              want.hit, want.statement_id, want.evicted, want.evicted_id);
                     $display("          got hit=%0d id=%0d ev=%0d ev_id=%0d",
                              rsp_if.hit, rsp_if.statement_id, rsp_if.evicted,
                              rsp_if.evicted_id);
                  end
                  mismatch_count++;
               end
            end
         end
         // long hold-off when asked, else random stalls
         if (rsp_stall_left == 0 && rsp_stalls_started < rsp_stalls_requested) begin
            rsp_stalls_started++;
            rsp_stall_left = RSP_STALL_LEN;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("statement_cache_lfu_table_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_stmt(input logic op, input logic [KEY_WIDTH-1:0] hi,
                            input logic [KEY_WIDTH-1:0] lo);
      stmt_req_type item;
      item.op = op;
      item.hi = hi;
      item.lo = lo;
      stmts_to_send.push_back(item);
   endtask

   // Block until all sent beats are answered
   task automatic wait_drained();
      do @(negedge clock);
      while (stmts_to_send.size() != 0 || req_if.valid || answers_due.size() != 0);
   endtask

   // Register write, only with the block idle
   task automatic write_cache_limit(input logic [LIMIT_WIDTH-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      shadow_limit = value;
      limit_writes++;
      @(negedge clock);
   endtask

   // Random traffic: a pool of keys sized around the limit, plus near misses and noise
   task automatic queue_random_stmts(input int unsigned lim, input int count);
      stmt_key_type pool [$];
      stmt_key_type key;
      stmt_req_type item;
      int pool_n;
      int k;
      int pick;
      int roll;
      pool_n = ((lim > CAPACITY) ? CAPACITY : lim) + $urandom_range(2, 12);
      for (k = 0; k < pool_n; k++) begin
         key.hi = {$urandom, $urandom};
         key.lo = {$urandom, $urandom};
         roll = $urandom_range(0, 5);
         // some keys share one half with their neighbor
         if (k > 0 && roll == 0) key.hi = pool[k-1].hi;
         if (k > 0 && roll == 1) key.lo = pool[k-1].lo;
         pool.push_back(key);
      end
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) pick = $urandom_range(0, pool_n - 1);
         else pick = $urandom_range(0, $urandom_range(0, pool_n - 1));
         item.hi = pool[pick].hi;
         item.lo = pool[pick].lo;
         if (roll < 10) begin
            item.hi = {$urandom, $urandom};
            item.lo = {$urandom, $urandom};
         end else if (roll < 15) begin
            if ($urandom_range(0, 1)) item.hi = item.hi ^ (64'd1 << $urandom_range(0, 63));
            else item.lo = item.lo ^ (64'd1 << $urandom_range(0, 63));
         end
         item.op = $urandom_range(0, 1) ? OP_BIND : OP_PARSE;
         stmts_to_send.push_back(item);
      end
   endtask

   // Main sequence
   initial begin
      int unsigned phase_limit [RANDOM_PHASES];
      int ph;
      int count;
      int s;
      phase_limit = '{64, 2, 127, 1, 16, 0, 40, 5, 63, 64};
      for (s = 0; s < CAPACITY; s++) begin
         shadow_used[s]  = 1'b0;
         shadow_kh[s]    = '0;
         shadow_kl[s]    = '0;
         shadow_sid[s]   = '0;
         shadow_binds[s] = '0;
      end
      csr_if.valid           = 1'b0;
      csr_if.data            = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // limit zero: empty cache inserts plainly, later misses evict
      write_cache_limit(LIMIT_WIDTH'(0));
      push_stmt(OP_PARSE, '0, '0);
      push_stmt(OP_PARSE, '1, '1);
      push_stmt(OP_BIND,  '1, '1);
      push_stmt(OP_PARSE, '0, '0);

      // limit one
      write_cache_limit(LIMIT_WIDTH'(1));
      push_stmt(OP_BIND,  64'h8000_0000_0000_0000, '0);
      push_stmt(OP_BIND,  64'h8000_0000_0000_0000, '0);
      push_stmt(OP_PARSE, '0, 64'd1);

      // limit three: tie on zero binds goes to the older id
      write_cache_limit(LIMIT_WIDTH'(3));
      push_stmt(OP_PARSE, 64'd1, 64'd1);
      push_stmt(OP_PARSE, 64'd2, 64'd2);
      push_stmt(OP_BIND,  64'd1, 64'd1);
      push_stmt(OP_PARSE, 64'd3, 64'd3);
      push_stmt(OP_PARSE, 64'd4, 64'd4);
      push_stmt(OP_BIND,  64'd2, 64'd2);

      // limit above capacity
      write_cache_limit(LIMIT_WIDTH'(127));
      push_stmt(OP_PARSE, {32{2'b01}}, {32{2'b10}});
      push_stmt(OP_BIND,  {32{2'b01}}, {32{2'b10}});
      push_stmt(OP_PARSE, {32{2'b10}}, {32{2'b01}});
      push_stmt(OP_BIND,  '1, '0);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_cache_limit(LIMIT_WIDTH'(phase_limit[ph]));
         no_idle = (ph == 6);
         count = (ph == 2) ? 130 : 78;
         // receiver holds off while the sender keeps offering
         if (ph == 2) rsp_stalls_requested++;
         queue_random_stmts(phase_limit[ph], count);
         // sender pauses mid-phase until everything is answered
         if (ph == 4) begin
            do @(negedge clock);
            while (stmts_to_send.size() > count / 2);
            sender_hold = 1'b1;
            do @(negedge clock);
            while (req_if.valid || answers_due.size() != 0);
            sender_hold = 1'b0;
         end
      end

      wait_drained();
      no_idle = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d statements: %0d hits, %0d misses, %0d evictions",
               stmts_sent, hits_seen, stmts_sent - hits_seen, evicts_seen);
      $display("across %0d cache limit writes (0, 1, 64 and 127 among them), %0d mismatches",
               limit_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("statement_cache_lfu_table_core test passed");
      end else begin
         $display("statement_cache_lfu_table_core test failed");
      end
      $finish;
   end

endmodule

// ===== statement_cache_lfu_table_core.f =====
hdl/sclt_pkg.sv
hdl/sclt_if.sv
hdl/sclt_datapath.sv
hdl/sclt_controller.sv
hdl/statement_cache_lfu_table_core.sv
sim/statement_cache_lfu_table_core_tb.sv
